@@ rtl/hci_iso_sdu_fragmenter_top_defines.svh @@
// Assertion macros used by the fragmenter top level.
`ifndef HCI_ISO_SDU_FRAGMENTER_TOP_DEFINES_SVH
`define HCI_ISO_SDU_FRAGMENTER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ISF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isf check failed");

// Antecedent implies consequent in the next cycle.
`define ISF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isf check failed");

`endif

@@ rtl/isf_pkg.sv @@
// Types and constants shared by the ISO SDU fragmenter modules.
`default_nettype none
package isf_pkg;

  localparam logic [11:0] FRAG_SIZE_RESET = 12'd300;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Data total length of an 8-byte header counts the 4 extra header bytes.
  localparam logic [12:0] HDR_EXTRA = 13'd4;

  // Position of the data byte in the output sequence of one queue entry.
  localparam logic [3:0] LONG_DATA_PHASE  = 4'd8;
  localparam logic [3:0] SHORT_DATA_PHASE = 4'd4;
  localparam logic [3:0] BARE_DATA_PHASE  = 4'd0;

  // Header byte offsets.
  localparam logic [3:0] HB_HANDLE_LO = 4'd0;
  localparam logic [3:0] HB_HANDLE_HI = 4'd1;
  localparam logic [3:0] HB_LEN_LO    = 4'd2;
  localparam logic [3:0] HB_LEN_HI    = 4'd3;
  localparam logic [3:0] HB_SEQ_LO    = 4'd4;
  localparam logic [3:0] HB_SEQ_HI    = 4'd5;
  localparam logic [3:0] HB_SDU_LO    = 4'd6;
  localparam logic [3:0] HB_SDU_HI    = 4'd7;

  typedef enum logic [1:0] {
    PB_FIRST    = 2'd0,
    PB_CONT     = 2'd1,
    PB_COMPLETE = 2'd2,
    PB_LAST     = 2'd3
  } pb_t;

  // One classified input item: a data byte, optionally preceded by a header.
  typedef struct packed {
    logic [7:0]  data;
    logic [11:0] handle;
    pb_t         pb;
    logic        hdr;
    logic        long_hdr;
    logic [11:0] plen;
    logic [11:0] sdu_len;
    logic        pkt_end;
  } frag_op_t;

endpackage
`default_nettype wire

@@ rtl/isf_if.sv @@
// Channel interfaces of the ISO SDU fragmenter: input bytes, packet bytes, config.
`default_nettype none
interface isf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [11:0] iso_handle;
  logic [11:0] sdu_length;
  modport source (output valid, data_byte, iso_handle, sdu_length, input ready);
  modport sink   (input valid, data_byte, iso_handle, sdu_length, output ready);
endinterface

interface isf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_start;
  logic       packet_end;
  logic       run_last;
  modport source (output valid, out_byte, packet_start, packet_end, run_last, input ready);
  modport sink   (input valid, out_byte, packet_start, packet_end, run_last, output ready);
endinterface

interface isf_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] fragment_size;
  modport source (output valid, fragment_size, input ready);
  modport sink   (input valid, fragment_size, output ready);
endinterface
`default_nettype wire

@@ rtl/isf_front.sv @@
// Front end: accepts SDU bytes, tracks SDU and packet position, classifies each byte.
`default_nettype none
module isf_front (
  input  wire logic      clk,
  input  wire logic      rst,
  isf_in_if.sink         sdu,
  isf_cfg_if.sink        cfg,
  input  wire logic      q_full,
  output logic           push,
  output isf_pkg::frag_op_t op
);
  import isf_pkg::*;

  logic [11:0] frag_size;
  logic [11:0] sdu_left;
  logic [11:0] pkt_left;
  logic        first_done;

  logic        idle;
  logic        drop;
  logic [11:0] sdu_cur;
  logic [11:0] pkt_cur;
  logic        first_cur;
  logic [11:0] frag;
  logic        fits;
  logic [11:0] plen;
  logic        open_pkt;
  logic [11:0] pkt_left_next;
  logic [11:0] sdu_left_next;
  logic        accept;

  assign cfg.ready = 1'b1;
  assign sdu.ready = !q_full;
  assign accept    = sdu.valid && sdu.ready;

  always_comb begin
    idle          = (sdu_left == 12'd0);
    drop          = idle && (sdu.sdu_length == 12'd0);
    sdu_cur       = idle ? sdu.sdu_length : sdu_left;
    pkt_cur       = idle ? 12'd0 : pkt_left;
    first_cur     = idle ? 1'b0 : first_done;
    frag          = (frag_size == 12'd0) ? 12'd1 : frag_size;
    fits          = (sdu_cur <= frag);
    plen          = fits ? sdu_cur : frag;
    open_pkt      = (pkt_cur == 12'd0);
    pkt_left_next = (open_pkt ? plen : pkt_cur) - 12'd1;
    sdu_left_next = sdu_cur - 12'd1;

    op.data     = sdu.data_byte;
    op.handle   = sdu.iso_handle;
    op.hdr      = open_pkt;
    op.long_hdr = !first_cur;
    if (!first_cur) begin
      op.pb = fits ? PB_COMPLETE : PB_FIRST;
    end else begin
      op.pb = fits ? PB_LAST : PB_CONT;
    end
    op.plen     = plen;
    op.sdu_len  = sdu_cur;
    op.pkt_end  = (pkt_left_next == 12'd0);
  end

  assign push = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_size  <= FRAG_SIZE_RESET;
      sdu_left   <= 12'd0;
      pkt_left   <= 12'd0;
      first_done <= 1'b0;
    end else begin
      if (cfg.valid) begin
        frag_size <= cfg.fragment_size;
      end
      if (push) begin
        sdu_left   <= sdu_left_next;
        pkt_left   <= pkt_left_next;
        first_done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/isf_queue.sv @@
// Short queue of classified items between the front and back ends.
`default_nettype none
module isf_queue #(
  parameter int unsigned DEPTH = isf_pkg::QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire isf_pkg::frag_op_t wr_op,
  input  wire logic      pop,
  output isf_pkg::frag_op_t head,
  output logic           empty,
  output logic           full
);
  import isf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frag_op_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/isf_back.sv @@
// Back end: expands each queued item into header bytes and its data byte.
`default_nettype none
module isf_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire isf_pkg::frag_op_t head,
  input  wire logic      q_valid,
  output logic           pop,
  isf_out_if.source      pkt
);
  import isf_pkg::*;

  logic [3:0]  phase;
  logic [3:0]  data_phase;
  logic        at_data;
  logic        load;
  logic        step;
  logic [12:0] total_len;
  logic [7:0]  byte_sel;

  always_comb begin
    if (!head.hdr) begin
      data_phase = BARE_DATA_PHASE;
    end else if (head.long_hdr) begin
      data_phase = LONG_DATA_PHASE;
    end else begin
      data_phase = SHORT_DATA_PHASE;
    end
    at_data   = (phase == data_phase);
    load      = !pkt.valid || pkt.ready;
    step      = q_valid && load;
    pop       = step && at_data;
    total_len = head.long_hdr ? ({1'b0, head.plen} + HDR_EXTRA) : {1'b0, head.plen};

    if (at_data) begin
      byte_sel = head.data;
    end else begin
      case (phase)
        HB_HANDLE_LO: byte_sel = head.handle[7:0];
        HB_HANDLE_HI: byte_sel = {2'b00, head.pb, head.handle[11:8]};
        HB_LEN_LO:    byte_sel = total_len[7:0];
        HB_LEN_HI:    byte_sel = {3'b000, total_len[12:8]};
        HB_SEQ_LO, HB_SEQ_HI: byte_sel = 8'd0;
        HB_SDU_LO:    byte_sel = head.sdu_len[7:0];
        HB_SDU_HI:    byte_sel = {4'b0000, head.sdu_len[11:8]};
        default:      byte_sel = head.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 4'd0;
      pkt.valid <= 1'b0;
    end else if (step) begin
      pkt.valid <= 1'b1;
      phase     <= at_data ? 4'd0 : phase + 4'd1;
    end else if (pkt.ready) begin
      pkt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pkt.out_byte     <= byte_sel;
      pkt.packet_start <= head.hdr && (phase == HB_HANDLE_LO);
      pkt.packet_end   <= at_data && head.pkt_end;
      pkt.run_last     <= at_data;
    end
  end
endmodule
`default_nettype wire

@@ rtl/hci_iso_sdu_fragmenter_top.sv @@
// Top level of the HCI ISO SDU fragmenter.
//
// The sdu channel takes one SDU payload byte per item together with its
// connection handle and the total SDU length. The pkt channel returns the
// byte stream of HCI ISO data packets, one byte per item, with flags for the
// first header byte of a packet, the final data byte of a packet, and the
// last output byte caused by one input item. The cfg channel writes the
// fragment size (reset value 300; zero acts as one) and is always ready.
// A byte that opens a packet produces 8 header bytes (complete or first
// fragment) or 4 header bytes (continuation or last fragment) before itself.
// An accepted item passes through the queue before its bytes are output.
// Throughput is one input item per cycle for bytes inside a packet while the
// receiver is ready; header bytes take output slots as well. The front end
// classifies bytes and keeps SDU position, a queue of QDEPTH entries holds
// classified items, and the back end serializes headers into a registered
// output. When the receiver stalls, the output byte holds, the queue fills
// and sdu.ready drops only once it is full. A byte that arrives between SDUs
// with an SDU length of zero is accepted and dropped. Reset is synchronous
// and returns the block to idle between SDUs with the queue empty.
`default_nettype none
`include "hci_iso_sdu_fragmenter_top_defines.svh"
module hci_iso_sdu_fragmenter_top #(
  parameter int unsigned QDEPTH = isf_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  isf_in_if.sink    sdu,
  isf_cfg_if.sink   cfg,
  isf_out_if.source pkt
);
  import isf_pkg::*;

  frag_op_t push_op;
  frag_op_t head_op;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  isf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sdu    (sdu),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .op     (push_op)
  );

  isf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_op (push_op),
    .pop   (pop),
    .head  (head_op),
    .empty (q_empty),
    .full  (q_full)
  );

  isf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head_op),
    .q_valid (!q_empty),
    .pop     (pop),
    .pkt     (pkt)
  );

  // A header byte is never the last byte of an item.
  `ISF_ASSERT_SAME(a_start_not_last, pkt.valid && pkt.packet_start, !pkt.run_last)
  // A packet only ends on the data byte that closes an item.
  `ISF_ASSERT_SAME(a_end_is_last, pkt.valid && pkt.packet_end, pkt.run_last)
  // After the first header byte is taken, the next header byte follows at once.
  `ISF_ASSERT_NEXT(a_hdr_continues, pkt.valid && pkt.ready && pkt.packet_start,
                   pkt.valid && !pkt.packet_start)
  // A full queue always has an item for the back end.
  `ISF_ASSERT_SAME(a_full_not_empty, q_full, !q_empty)

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the HCI ISO SDU fragmenter: directed table, long SDUs, random SDUs.
module testbench;
  import isf_pkg::*;

  // An 8-byte header counts four header bytes in its data total length.
  localparam logic [12:0] LONG_HDR_EXTRA = 13'd4;
  // Cycles allowed after the last expected byte so that a dropped item is finished.
  localparam int SETTLE_CYCLES = 12;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off that fills the internal queue.
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_ITEMS = 100;
  // SDU bytes sent with one fragment size before the next one is chosen.
  localparam int PHASE_ITEMS = 25;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One row of the directed plan. For a configuration row, slen carries the
  // value written to fragment_size. When pin is set, the number of packet
  // bytes and the first of them are known by inspection and typed in.
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic [11:0] handle;
    logic [11:0] slen;
    logic        pin;
    logic [3:0]  cnt;
    logic [7:0]  first;
  } plan_row_t;

  // One byte of the packet stream with its flags.
  typedef struct packed {
    logic [7:0] value;
    logic       pkt_start;
    logic       pkt_end;
    logic       run_last;
  } pkt_byte_t;

  localparam int PLAN_ROWS = 23;

  // Directed plan. The comment on each row names the case it covers.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BYTE, 8'h55, 12'h123, 12'd0,    1'b1, 4'd0, 8'h00}, // zero length while idle: dropped
    '{ROW_BYTE, 8'hFF, 12'hFFF, 12'd1,    1'b1, 4'd9, 8'hFF}, // one-byte SDU, all-ones fields
    '{ROW_BYTE, 8'h00, 12'h000, 12'd1,    1'b1, 4'd9, 8'h00}, // one-byte SDU, all-zero fields
    '{ROW_BYTE, 8'h01, 12'hABC, 12'd3,    1'b1, 4'd9, 8'hBC}, // complete packet opens
    '{ROW_BYTE, 8'h80, 12'h321, 12'd0,    1'b1, 4'd1, 8'h80}, // length changes inside the SDU
    '{ROW_BYTE, 8'h7F, 12'hFFF, 12'hFFF,  1'b1, 4'd1, 8'h7F}, // and again, to the largest value
    '{ROW_CFG,  8'h00, 12'h000, 12'd1,    1'b0, 4'd0, 8'h00}, // one byte per packet
    '{ROW_BYTE, 8'hA5, 12'h5A5, 12'd3,    1'b1, 4'd9, 8'hA5}, // first fragment
    '{ROW_BYTE, 8'h5A, 12'h5A5, 12'd3,    1'b1, 4'd5, 8'hA5}, // continuation fragment
    '{ROW_BYTE, 8'hC3, 12'h5A5, 12'd3,    1'b1, 4'd5, 8'hA5}, // last fragment
    '{ROW_CFG,  8'h00, 12'h000, 12'd0,    1'b0, 4'd0, 8'h00}, // zero fragment size acts as one
    '{ROW_BYTE, 8'h11, 12'h0F0, 12'd2,    1'b1, 4'd9, 8'hF0}, // first fragment
    '{ROW_BYTE, 8'h22, 12'h00F, 12'd0,    1'b1, 4'd5, 8'h0F}, // handle changes at a packet start
    '{ROW_CFG,  8'h00, 12'h000, 12'd2,    1'b0, 4'd0, 8'h00},
    '{ROW_BYTE, 8'hAA, 12'h800, 12'd5,    1'b1, 4'd9, 8'h00}, // first fragment of three
    '{ROW_BYTE, 8'h55, 12'h800, 12'd5,    1'b0, 4'd0, 8'h00},
    '{ROW_BYTE, 8'hF0, 12'h7FF, 12'd5,    1'b1, 4'd5, 8'hFF}, // continuation, new handle
    '{ROW_BYTE, 8'h0F, 12'h7FF, 12'd5,    1'b0, 4'd0, 8'h00},
    '{ROW_BYTE, 8'h3C, 12'h400, 12'd5,    1'b1, 4'd5, 8'h00}, // last fragment of one byte
    '{ROW_CFG,  8'h00, 12'h000, 12'hFFF,  1'b0, 4'd0, 8'h00}, // largest fragment size
    '{ROW_BYTE, 8'h99, 12'h001, 12'd2,    1'b1, 4'd9, 8'h01},
    '{ROW_BYTE, 8'h66, 12'h001, 12'd2,    1'b0, 4'd0, 8'h00},
    '{ROW_BYTE, 8'hEE, 12'hFFF, 12'd0,    1'b1, 4'd0, 8'h00}  // zero length between SDUs again
  };

  logic clk = 1'b0;
  logic rst;

  isf_in_if  sdu_ch ();
  isf_out_if pkt_ch ();
  isf_cfg_if cfg_ch ();

  hci_iso_sdu_fragmenter_top dut (
    .clk (clk),
    .rst (rst),
    .sdu (sdu_ch),
    .cfg (cfg_ch),
    .pkt (pkt_ch)
  );

  // Period of two time units: high for one, low for one.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the fragmenter state, advanced on every accepted item.
  logic [11:0] frag_size;
  logic [11:0] sdu_left;
  logic [11:0] pkt_left;
  logic        first_done;

  // Packet bytes still owed by the block, oldest first.
  pkt_byte_t pkt_byte_q [$];

  // Side information for the item on the input channel, set with its payload.
  logic       cur_pin;
  logic [3:0] cur_cnt;
  logic [7:0] cur_first;

  // Steady stretch: neither side inserts idle cycles while this is set.
  bit steady;
  // Request for one long receiver hold-off, taken up by the receiver process.
  bit hold_req;
  int hold_left;

  int mismatches;
  int items_sent;
  int items_taken;
  int bytes_checked;
  int cfg_writes;
  int sdus_sent;
  int stall_cycles;

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH: %s", msg);
  endfunction

  function automatic void owe_byte(logic [7:0] v, logic s, logic e, logic r);
    pkt_byte_t b;
    b.value = v;
    b.pkt_start = s;
    b.pkt_end = e;
    b.run_last = r;
    pkt_byte_q.push_back(b);
  endfunction

  // Works out the packet bytes that one accepted SDU byte causes and appends
  // them to the queue. Returns how many were appended.
  function automatic int frame_sdu_byte(logic [7:0] d, logic [11:0] h, logic [11:0] l);
    logic [11:0] frag;
    logic [11:0] plen;
    logic [15:0] hdr_word;
    logic [12:0] total;
    pb_t         pb;
    int          n0;
    n0 = pkt_byte_q.size();
    frag = (frag_size == 12'd0) ? 12'd1 : frag_size;
    if (sdu_left == 12'd0) begin
      // A byte with no length between SDUs is simply dropped.
      if (l == 12'd0) return 0;
      sdu_left = l;
      pkt_left = 12'd0;
      first_done = 1'b0;
    end
    if (pkt_left == 12'd0) begin
      plen = (sdu_left < frag) ? sdu_left : frag;
      if (!first_done)
        pb = (sdu_left <= frag) ? PB_COMPLETE : PB_FIRST;
      else
        pb = (plen == sdu_left) ? PB_LAST : PB_CONT;
      hdr_word = {2'b00, pb, h};
      owe_byte(hdr_word[7:0], 1'b1, 1'b0, 1'b0);
      owe_byte(hdr_word[15:8], 1'b0, 1'b0, 1'b0);
      if (pb == PB_FIRST || pb == PB_COMPLETE) begin
        total = {1'b0, plen} + LONG_HDR_EXTRA;
        owe_byte(total[7:0], 1'b0, 1'b0, 1'b0);
        owe_byte({3'b000, total[12:8]}, 1'b0, 1'b0, 1'b0);
        owe_byte(8'h00, 1'b0, 1'b0, 1'b0);
        owe_byte(8'h00, 1'b0, 1'b0, 1'b0);
        owe_byte(sdu_left[7:0], 1'b0, 1'b0, 1'b0);
        owe_byte({4'h0, sdu_left[11:8]}, 1'b0, 1'b0, 1'b0);
      end else begin
        owe_byte(plen[7:0], 1'b0, 1'b0, 1'b0);
        owe_byte({4'h0, plen[11:8]}, 1'b0, 1'b0, 1'b0);
      end
      pkt_left = plen;
      first_done = 1'b1;
    end
    pkt_left = pkt_left - 12'd1;
    sdu_left = sdu_left - 12'd1;
    owe_byte(d, 1'b0, pkt_left == 12'd0, 1'b1);
    return pkt_byte_q.size() - n0;
  endfunction

  function automatic void check_pkt_byte(pkt_byte_t got);
    pkt_byte_t want;
    if (pkt_byte_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %h start %b end %b last %b",
                              got.value, got.pkt_start, got.pkt_end, got.run_last));
      return;
    end
    want = pkt_byte_q.pop_front();
    bytes_checked++;
    if (got.value != want.value || got.pkt_start != want.pkt_start ||
        got.pkt_end != want.pkt_end || got.run_last != want.run_last)
      flag_mismatch($sformatf(
        "byte %0d: expected %h start %b end %b last %b, got %h start %b end %b last %b",
        bytes_checked, want.value, want.pkt_start, want.pkt_end, want.run_last,
        got.value, got.pkt_start, got.pkt_end, got.run_last));
  endfunction

  // Monitor: every handshake is seen at the rising edge, before the block's
  // own registers update, so all three channels read settled values. Output
  // bytes are checked before the new input is predicted; a new input cannot
  // produce a byte in the same cycle anyway. The watchdog counts edges at
  // which no channel moved an item.
  always @(posedge clk) begin
    bit        moved;
    pkt_byte_t got;
    int        n;
    int        base;
    moved = 1'b0;
    if (!rst) begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        moved = 1'b1;
        got.value = pkt_ch.out_byte;
        got.pkt_start = pkt_ch.packet_start;
        got.pkt_end = pkt_ch.packet_end;
        got.run_last = pkt_ch.run_last;
        check_pkt_byte(got);
      end
      if (sdu_ch.valid && sdu_ch.ready) begin
        moved = 1'b1;
        items_taken++;
        base = pkt_byte_q.size();
        n = frame_sdu_byte(sdu_ch.data_byte, sdu_ch.iso_handle, sdu_ch.sdu_length);
        // Rows of the directed plan with typed-in values are held to them too.
        if (cur_pin && (n != int'(cur_cnt) || (n > 0 && pkt_byte_q[base].value != cur_first)))
          flag_mismatch($sformatf("item %0d: expected %0d bytes starting %h, predicted %0d",
                                  items_taken, cur_cnt, cur_first, n));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        frag_size = cfg_ch.fragment_size;
        cfg_writes++;
      end
      if (moved)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d bytes still owed",
                 STALL_LIMIT, pkt_byte_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: ready changes only at the falling edge. With a chance of about
  // six in a hundred it stalls, never during the steady stretch, and once it holds
  // off for a long stretch so the queue inside the block fills and the
  // input channel is pushed back.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pkt_ch.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      pkt_ch.ready = 1'b0;
    end else begin
      pkt_ch.ready = steady || ($urandom_range(0, 99) >= 6);
    end
  end

  // Offers one SDU byte and returns at the falling edge after it was taken.
  // Callers are always at a falling edge, so payload changes never meet a
  // rising edge.
  task automatic send_item(input logic [7:0] d, input logic [11:0] h, input logic [11:0] l,
                           input logic pin, input logic [3:0] cnt, input logic [7:0] first);
    while (!steady && $urandom_range(0, 99) < 6) begin
      sdu_ch.valid = 1'b0;
      @(negedge clk);
    end
    sdu_ch.valid = 1'b1;
    sdu_ch.data_byte = d;
    sdu_ch.iso_handle = h;
    sdu_ch.sdu_length = l;
    cur_pin = pin;
    cur_cnt = cnt;
    cur_first = first;
    do @(posedge clk); while (!sdu_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Sends a whole SDU. With noise set, bytes after the first carry random
  // handles and lengths: the block must ignore the length and take the
  // handle only where a packet opens.
  task automatic send_sdu(input logic [11:0] h, input int len, input bit noise);
    logic [11:0] hh;
    logic [11:0] ll;
    for (int i = 0; i < len; i++) begin
      hh = h;
      ll = 12'(len);
      if (noise && i > 0) begin
        hh = 12'($urandom_range(0, 4095));
        ll = 12'($urandom_range(0, 4095));
      end
      send_item(8'($urandom_range(0, 255)), hh, ll, 1'b0, 4'd0, 8'h00);
    end
    sdus_sent++;
  endtask

  // The fragment size is only changed with the block idle: every owed byte
  // has come out, and a dropped item has had time to leave the pipeline.
  task automatic write_frag(input logic [11:0] v);
    sdu_ch.valid = 1'b0;
    while (pkt_byte_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.fragment_size = v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int          random_items;
    int          phase;
    int          phase_items;
    int          len;
    logic [11:0] next_frag;
    bit          held;
    logic [11:0] frag_cycle [8];
    frag_cycle = '{12'd3, 12'd1, 12'hFFF, 12'd7, 12'd2, 12'd0, 12'd16, 12'd5};

    // Every input is known from time zero.
    rst = 1'b1;
    sdu_ch.valid = 1'b0;
    sdu_ch.data_byte = 8'h00;
    sdu_ch.iso_handle = 12'h000;
    sdu_ch.sdu_length = 12'h000;
    cfg_ch.valid = 1'b0;
    cfg_ch.fragment_size = 12'h000;
    pkt_ch.ready = 1'b0;
    cur_pin = 1'b0;
    cur_cnt = 4'd0;
    cur_first = 8'h00;
    steady = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    mismatches = 0;
    items_sent = 0;
    items_taken = 0;
    bytes_checked = 0;
    cfg_writes = 0;
    sdus_sent = 0;
    stall_cycles = 0;
    frag_size = FRAG_SIZE_RESET;
    sdu_left = 12'd0;
    pkt_left = 12'd0;
    first_done = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // One byte past the reset fragment size: a full first fragment followed
    // by a one-byte last fragment, which pins down the reset value. Neither
    // side idles during this SDU, so it is also the long steady stretch.
    steady = 1'b1;
    send_sdu(12'h3C5, 301, 1'b0);
    steady = 1'b0;
    sdus_sent--;

    // Directed plan.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_CFG)
        write_frag(plan[r].slen);
      else
        send_item(plan[r].data, plan[r].handle, plan[r].slen,
                  plan[r].pin, plan[r].cnt, plan[r].first);
    end

    // Random part: phases of whole SDUs, each with its own fragment size.
    // Lengths stay short so most SDUs split into several fragments.
    random_items = 0;
    phase = 0;
    held = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0)
        next_frag = 12'($urandom_range(1, 12));
      else
        next_frag = frag_cycle[phase % 8];
      write_frag(next_frag);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Stray zero-length bytes between SDUs.
        if ($urandom_range(0, 99) < 5) begin
          send_item(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)), 12'd0,
                    1'b0, 4'd0, 8'h00);
        end
        if ($urandom_range(0, 9) == 0)
          len = $urandom_range(20, 40);
        else
          len = $urandom_range(1, 20);
        if (!held && random_items >= 20) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
        send_sdu(12'($urandom_range(0, 4095)), len, $urandom_range(0, 4) == 0);
        phase_items += len;
        random_items += len;
      end
      phase++;
    end
    sdu_ch.valid = 1'b0;

    // Drain, then give the block time to show any byte it should not send.
    while (pkt_byte_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (pkt_byte_q.size() != 0)
      flag_mismatch($sformatf("%0d bytes never arrived", pkt_byte_q.size()));

    $display("Sent %0d SDU bytes in %0d random SDUs plus directed items, %0d config writes.",
             items_sent, sdus_sent, cfg_writes);
    $display("Checked %0d packet bytes; %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
